/* hdl/ifcrc_pkg.sv */
package ifcrc_pkg;

    localparam int unsigned MAX_LEN = 4096;

    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned LEN_W     = 13;
    localparam int unsigned CRC_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_ALL_ONES       = 32'hFFFF_FFFF;
    // bit reversal of the generator 0x04C11DB7
    localparam logic [CRC_W-1:0] CRC_POLY_REFLECTED = 32'hEDB8_8320;

    localparam logic [LEN_W-1:0]     MAX_LEN_VAL     = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0]     MAX_LEN_RESET   = 13'd4096;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd500;
    localparam logic [TIMEOUT_W-1:0] IDLE_SATURATE   = 16'hFFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN      = 2'd1;

    // item kind codes
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // end cause codes
    localparam logic CAUSE_IDLE   = 1'b0;
    localparam logic CAUSE_LENGTH = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } ifcrc_in_t;

    typedef struct packed {
        logic [CRC_W-1:0] frame_crc;
        logic [LEN_W-1:0] byte_count;
        logic             empty_frame;
        logic             end_cause;
    } ifcrc_out_t;

    // fold one byte into a reflected CRC-32; unrolls to one XOR network
    function automatic logic [CRC_W-1:0] crc_fold_byte(
        input logic [CRC_W-1:0] crc_in,
        input logic [7:0]       byte_in
    );
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, byte_in};
        for (int b = 0; b < 8; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFLECTED) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* hdl/idle_framed_crc32_unit.sv */
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid / in_ready     | in_item   (kind, data_byte)
// out     | output    | out_valid / out_ready   | out_item  (frame_crc, byte_count,
//         |           |                         |            empty_frame, end_cause)
// cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item is taken per cycle while the queue is not full; the byte-wide CRC
// XOR network and the counter compares fit between the frame state registers
// and the result queue. A closed frame shows on out in the cycle after the
// item that closed it is taken. The two-entry result queue sets the stall:
// input stops only while both entries hold results that have not been taken.
// rst_n resets frame state, last CRC, configuration and the queue at once.
module idle_framed_crc32_unit
    import ifcrc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  ifcrc_in_t            in_item,

    output logic                 out_valid,
    input  logic                 out_ready,
    output ifcrc_out_t           out_item,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMEOUT_W-1:0] cfg_data
);

    // configuration registers
    logic [TIMEOUT_W-1:0] idle_timeout_reg;
    logic [LEN_W-1:0]     max_len_reg;

    // frame state
    logic [CRC_W-1:0]     crc_accum_reg,   crc_accum_next;
    logic [LEN_W-1:0]     frame_bytes_reg, frame_bytes_next;
    logic [TIMEOUT_W-1:0] idle_ticks_reg,  idle_ticks_next;
    logic [CRC_W-1:0]     last_crc_reg,    last_crc_next;

    // result queue
    ifcrc_out_t           q_mem [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg, count_next;

    logic                 in_fire;
    logic                 out_fire;
    logic                 push;
    logic [LEN_W-1:0]     len_limit;
    logic [TIMEOUT_W-1:0] timeout;
    logic [CRC_W-1:0]     crc_upd;
    logic [LEN_W-1:0]     bytes_upd;
    logic [TIMEOUT_W-1:0] idle_upd;
    logic                 by_length;
    logic                 by_idle;
    logic                 close;
    ifcrc_out_t           result;

    assign cfg_ready = 1'b1;
    assign in_ready  = (count_reg != 2'd2);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != 2'd0);
    assign out_fire  = out_valid && out_ready;
    assign out_item  = q_mem[rd_ptr_reg];

    // Clamp the limits: zero acts as one, length never above MAX_LEN.
    always_comb
    begin
        if (max_len_reg == '0)
            len_limit = LEN_W'(1);
        else if (max_len_reg > MAX_LEN_VAL)
            len_limit = MAX_LEN_VAL;
        else
            len_limit = max_len_reg;
        timeout = (idle_timeout_reg == '0) ? TIMEOUT_W'(1) : idle_timeout_reg;
    end

    // Apply the item to the running state, then decide whether the frame closes.
    always_comb
    begin
        if (in_item.kind == KIND_BYTE)
        begin
            crc_upd   = crc_fold_byte(crc_accum_reg, in_item.data_byte);
            bytes_upd = frame_bytes_reg + LEN_W'(1);
            idle_upd  = '0;
        end
        else
        begin
            crc_upd   = crc_accum_reg;
            bytes_upd = frame_bytes_reg;
            idle_upd  = (idle_ticks_reg == IDLE_SATURATE) ? idle_ticks_reg
                                                         : idle_ticks_reg + TIMEOUT_W'(1);
        end

        by_length = (bytes_upd >= len_limit);
        by_idle   = (idle_upd >= timeout);
        close     = by_length || by_idle;

        // Build the result; an empty frame repeats the last CRC.
        if (bytes_upd == '0)
        begin
            result.frame_crc   = last_crc_reg;
            result.byte_count  = '0;
            result.empty_frame = 1'b1;
            result.end_cause   = CAUSE_IDLE;
        end
        else
        begin
            result.frame_crc   = crc_upd ^ CRC_ALL_ONES;
            result.byte_count  = bytes_upd;
            result.empty_frame = 1'b0;
            result.end_cause   = by_length ? CAUSE_LENGTH : CAUSE_IDLE;
        end

        // Hold state unless an item is taken; restart on close.
        crc_accum_next   = crc_accum_reg;
        frame_bytes_next = frame_bytes_reg;
        idle_ticks_next  = idle_ticks_reg;
        last_crc_next    = last_crc_reg;
        if (in_fire)
        begin
            if (close)
            begin
                crc_accum_next   = CRC_ALL_ONES;
                frame_bytes_next = '0;
                idle_ticks_next  = '0;
                if (!result.empty_frame)
                    last_crc_next = result.frame_crc;
            end
            else
            begin
                crc_accum_next   = crc_upd;
                frame_bytes_next = bytes_upd;
                idle_ticks_next  = idle_upd;
            end
        end
    end

    assign push = in_fire && close;

    always_comb
    begin
        unique case ({push, out_fire})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= TIMEOUT_RESET;
            max_len_reg      <= MAX_LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_IDLE_TIMEOUT)
                idle_timeout_reg <= cfg_data;
            else if (cfg_index == CFG_MAX_LEN)
                max_len_reg <= cfg_data[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_accum_reg   <= CRC_ALL_ONES;
            frame_bytes_reg <= '0;
            idle_ticks_reg  <= '0;
            last_crc_reg    <= CRC_ALL_ONES;
            wr_ptr_reg      <= 1'b0;
            rd_ptr_reg      <= 1'b0;
            count_reg       <= '0;
        end
        else
        begin
            crc_accum_reg   <= crc_accum_next;
            frame_bytes_reg <= frame_bytes_next;
            idle_ticks_reg  <= idle_ticks_next;
            last_crc_reg    <= last_crc_next;
            count_reg       <= count_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (out_fire)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    // Queue storage: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= result;
    end

endmodule

/* hdl/ifcrc_checker.sv */
module ifcrc_checker
    import ifcrc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  ifcrc_out_t out_item
);

    // a result stays offered until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the item was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_item))
        else $error("out_item changed while stalled");

    // empty flag and zero count go together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.empty_frame == (out_item.byte_count == '0)))
        else $error("empty_frame disagrees with byte_count");

    // an empty frame only closes on idle timeout
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.empty_frame |-> out_item.end_cause == CAUSE_IDLE)
        else $error("empty frame reported with length cause");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.byte_count <= MAX_LEN_VAL)
        else $error("byte_count above the length limit");

endmodule

bind idle_framed_crc32_unit ifcrc_checker u_ifcrc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import ifcrc_pkg::*;

    // writes to these indexes must leave both registers untouched
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_REG_3 = 2'd3;

    localparam int IDLE_PCT    = 28;
    localparam int STALL_LEN   = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int PRINT_CAP   = 100;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;

    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    ifcrc_in_t            in_item   = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    ifcrc_out_t           out_item;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIMEOUT_W-1:0] cfg_data  = '0;

    idle_framed_crc32_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Bytes and ticks waiting to be offered, and closed frames still owed by the block.
    ifcrc_in_t  rx_pending[$];
    ifcrc_out_t frames_due[$];
    ifcrc_out_t frame_want;

    int in_offered   = 0;
    int in_taken     = 0;
    int mismatches   = 0;
    int quiet_cycles = 0;
    int stall_count  = 0;

    bit idling_on    = 1'b1;
    bit stall_req    = 1'b0;
    bit stall_served = 1'b0;

    // Shadow of the block: running CRC, frame length, idle ticks, last reported CRC.
    logic [CRC_W-1:0]     run_crc     = CRC_ALL_ONES;
    logic [LEN_W-1:0]     run_len     = '0;
    logic [TIMEOUT_W-1:0] run_idle    = '0;
    logic [CRC_W-1:0]     prev_crc    = CRC_ALL_ONES;
    logic [TIMEOUT_W-1:0] set_timeout = TIMEOUT_RESET;
    logic [LEN_W-1:0]     set_max_len = MAX_LEN_RESET;

    // Zero acts as one; the length register is clamped to the build limit.
    function automatic logic [LEN_W-1:0] len_limit();
        logic [LEN_W-1:0] lim;
        lim = (set_max_len == '0) ? LEN_W'(1) : set_max_len;
        if (lim > MAX_LEN_VAL)
            lim = MAX_LEN_VAL;
        return lim;
    endfunction

    function automatic logic [TIMEOUT_W-1:0] idle_limit();
        return (set_timeout == '0) ? TIMEOUT_W'(1) : set_timeout;
    endfunction

    // Reflected CRC-32, one input bit at a time, LSB first.
    function automatic logic [CRC_W-1:0] crc32_shift_byte(
        input logic [CRC_W-1:0] c,
        input logic [7:0]       d
    );
        logic [CRC_W-1:0] acc;
        logic             fb;
        acc = c;
        for (int i = 0; i < 8; i++)
        begin
            fb  = acc[0] ^ d[i];
            acc = {1'b0, acc[CRC_W-1:1]} ^ (fb ? CRC_POLY_REFLECTED : '0);
        end
        return acc;
    endfunction

    // Advance the shadow state by one accepted item; queue the frame it closes, if any.
    task automatic fold_rx_item(input ifcrc_in_t it);
        logic [LEN_W-1:0]     lim;
        logic [TIMEOUT_W-1:0] tmo;
        ifcrc_out_t           res;
        lim = len_limit();
        tmo = idle_limit();
        if (it.kind == KIND_BYTE)
        begin
            run_crc  = crc32_shift_byte(run_crc, it.data_byte);
            run_len  = run_len + 1'b1;
            run_idle = '0;
        end
        else if (run_idle != IDLE_SATURATE)
        begin
            run_idle = run_idle + 1'b1;
        end
        if (run_len >= lim || run_idle >= tmo)
        begin
            if (run_len == '0)
            begin
                // empty frame reports the last real CRC and leaves it alone
                res.frame_crc   = prev_crc;
                res.byte_count  = '0;
                res.empty_frame = 1'b1;
                res.end_cause   = CAUSE_IDLE;
            end
            else
            begin
                res.frame_crc   = ~run_crc;
                res.byte_count  = run_len;
                res.empty_frame = 1'b0;
                // length wins when both limits are met
                res.end_cause   = (run_len >= lim) ? CAUSE_LENGTH : CAUSE_IDLE;
                prev_crc        = ~run_crc;
            end
            frames_due.push_back(res);
            run_crc  = CRC_ALL_ONES;
            run_len  = '0;
            run_idle = '0;
        end
    endtask

    task automatic log_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        mismatches++;
        // bound the log when a broken block floods it
        if (mismatches <= PRINT_CAP)
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    endtask

    // Input side: record every accepted item and predict its effect.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            fold_rx_item(in_item);
            in_taken <= in_taken + 1;
        end
    end

    // Input driver: hold the offered item until taken, then offer the next or idle.
    always @(negedge clk)
    begin
        if (rst_n && !(in_valid && in_taken != in_offered))
        begin
            if (rx_pending.size() != 0 && !(idling_on && $urandom_range(99) < IDLE_PCT))
            begin
                in_item    <= rx_pending.pop_front();
                in_valid   <= 1'b1;
                in_offered <= in_offered + 1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request to fill the block.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_req && !stall_served)
            begin
                out_ready <= 1'b0;
                if (stall_count == STALL_LEN - 1)
                    stall_served <= 1'b1;
                stall_count <= stall_count + 1;
            end
            else
            begin
                out_ready <= !(idling_on && $urandom_range(99) < IDLE_PCT);
            end
        end
    end

    // Result checker: compare each taken result with the oldest owed frame.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (frames_due.size() == 0)
            begin
                log_mismatch("result with nothing owed, crc", out_item.frame_crc, '0);
            end
            else
            begin
                frame_want = frames_due.pop_front();
                if (out_item.frame_crc !== frame_want.frame_crc)
                    log_mismatch("frame_crc", out_item.frame_crc, frame_want.frame_crc);
                if (out_item.byte_count !== frame_want.byte_count)
                    log_mismatch("byte_count", out_item.byte_count, frame_want.byte_count);
                if (out_item.empty_frame !== frame_want.empty_frame)
                    log_mismatch("empty_frame", out_item.empty_frame, frame_want.empty_frame);
                if (out_item.end_cause !== frame_want.end_cause)
                    log_mismatch("end_cause", out_item.end_cause, frame_want.end_cause);
            end
        end
    end

    // Watchdog: end the run when nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        ifcrc_in_t it;
        it.kind      = KIND_BYTE;
        it.data_byte = b;
        rx_pending.push_back(it);
    endtask

    task automatic queue_ticks(input int n);
        ifcrc_in_t it;
        for (int k = 0; k < n; k++)
        begin
            it.kind      = KIND_TICK;
            it.data_byte = 8'($urandom);
            rx_pending.push_back(it);
        end
    endtask

    // Mostly well-formed frames: a burst of bytes, maybe short pauses inside,
    // then a gap around the timeout. The rest is random noise items.
    task automatic queue_frames(input int budget);
        int queued;
        int burst;
        int gap;
        int lim;
        int tmo;
        queued = 0;
        lim    = int'(len_limit());
        tmo    = int'(idle_limit());
        while (queued < budget)
        begin
            if ($urandom_range(99) < 15)
            begin
                rx_pending.push_back(ifcrc_in_t'(9'($urandom)));
                queued++;
            end
            else
            begin
                burst = $urandom_range(1, (lim < 40) ? lim + 2 : 40);
                for (int k = 0; k < burst; k++)
                begin
                    queue_byte(8'($urandom));
                    queued++;
                    if (tmo > 1 && $urandom_range(99) < 10)
                    begin
                        gap = $urandom_range(1, tmo - 1);
                        queue_ticks(gap);
                        queued += gap;
                    end
                end
                gap = $urandom_range(0, tmo + 1);
                queue_ticks(gap);
                queued += gap;
            end
        end
    endtask

    // Wait until every item is taken and every owed frame has come out,
    // then let the last item settle before touching registers.
    task automatic drain();
        while (rx_pending.size() != 0 || in_valid || frames_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [TIMEOUT_W-1:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_IDLE_TIMEOUT)
            set_timeout = val;
        else if (idx == CFG_MAX_LEN)
            set_max_len = val[LEN_W-1:0];
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [TIMEOUT_W-1:0] tmo_pick;
        logic [TIMEOUT_W-1:0] len_pick;

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero registers act as one: an empty frame before any CRC reports all ones,
        // then single-byte frames close on length, then an empty frame repeats the last CRC.
        write_reg(CFG_IDLE_TIMEOUT, '0);
        write_reg(CFG_MAX_LEN, '0);
        queue_ticks(1);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_ticks(1);
        drain();

        // Length above the build limit clamps; the check string "123456789" closes on idle.
        write_reg(CFG_MAX_LEN, 16'hFFFF);
        write_reg(CFG_IDLE_TIMEOUT, 16'd2);
        for (int i = 0; i < 9; i++)
            queue_byte(8'(8'h31 + i));
        queue_ticks(2);
        queue_ticks(2);
        queue_byte(8'h80);
        queue_byte(8'h01);
        queue_ticks(2);
        drain();

        // Leave a frame open, then tighten both limits: the next tick meets both,
        // and length must win.
        write_reg(CFG_IDLE_TIMEOUT, 16'd5);
        write_reg(CFG_MAX_LEN, 16'd100);
        queue_byte(8'h5A);
        queue_byte(8'hA5);
        queue_byte(8'h3C);
        queue_ticks(2);
        drain();
        write_reg(CFG_MAX_LEN, 16'd2);
        write_reg(CFG_IDLE_TIMEOUT, 16'd1);
        queue_ticks(1);
        drain();

        // Random phases with fresh settings each time. The first closes a frame
        // on every byte while the receiver holds off; the third runs without idling.
        for (int p = 0; p < 6; p++)
        begin
            tmo_pick = (p == 0) ? 16'd1 : 16'($urandom_range(0, 16));
            len_pick = (p == 0) ? 16'd1 : 16'($urandom_range(0, 32));
            len_pick = len_pick | (16'($urandom_range(7)) << LEN_W);
            write_reg(CFG_IDLE_TIMEOUT, tmo_pick);
            write_reg(CFG_MAX_LEN, len_pick);
            if (p == 3)
                write_reg(CFG_NO_REG_2, 16'($urandom));
            if (p == 5)
                write_reg(CFG_NO_REG_3, 16'($urandom));
            stall_req = (p == 0);
            idling_on = (p != 2);
            queue_frames(290);
            drain();
        end
        idling_on = 1'b1;

        // Upper extremes: the longest timeout keeps a frame open at the full length
        // limit; pulling the timeout down to the ticks seen closes it on the next tick.
        write_reg(CFG_IDLE_TIMEOUT, 16'hFFFF);
        write_reg(CFG_MAX_LEN, 16'd4096);
        for (int i = 0; i < 40; i++)
            queue_byte(8'($urandom));
        queue_ticks(30);
        drain();
        write_reg(CFG_IDLE_TIMEOUT, 16'd31);
        queue_ticks(1);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_ticks(31);
        drain();

        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
